### rtl/core/lad_pkg.sv
`timescale 1ns / 1ps

package lad_pkg;

   // coefficient registers are all unsigned 16 bit
   localparam int COEF_BITS = 16;
   localparam int GAIN_FRAC = 14;
   localparam int RES_FRAC  = 12;
   localparam int CUT_FRAC  = 16;

   // poles are Q3.x: sign plus three integer bits
   localparam int POLE_INT  = 4;
   localparam int NUM_POLES = 4;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [COEF_BITS-1:0] coef_type;

   typedef enum logic [1:0] {
      REG_CUTOFF    = 2'd0,
      REG_RESONANCE = 2'd1,
      REG_IN_GAIN   = 2'd2,
      REG_OUT_GAIN  = 2'd3
   } reg_index_type;

   // occupancy of the input scaling stages
   typedef struct packed {
      logic loaded;
      logic scaled;
      logic mixed;
   } front_busy_type;

endpackage

### rtl/core/lad_front.sv
`timescale 1ns / 1ps

module lad_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int STATE_BITS  = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  lad_pkg::coef_type             input_gain,
   input  lad_pkg::coef_type             resonance_amount,
   input  logic signed [STATE_BITS-1:0]  stage_four,
   output logic signed [STATE_BITS-1:0]  mix,
   output logic                          mix_valid,
   output lad_pkg::front_busy_type       busy
);
   import lad_pkg::*;

   localparam int POLE_FRAC    = STATE_BITS - POLE_INT;
   localparam int SHIFT        = SAMPLE_BITS - 1 + GAIN_FRAC - POLE_FRAC;
   localparam int SHR          = (SHIFT > 0) ? SHIFT : 0;
   localparam int SHL          = (SHIFT < 0) ? -SHIFT : 0;
   localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS + 1;
   localparam int EXT_BITS     = PROD_BITS + SHL + 1;
   localparam int FB_PROD_BITS = STATE_BITS + COEF_BITS + 1;
   localparam int FB_BITS      = FB_PROD_BITS - RES_FRAC;
   localparam int DIFF_BITS    = FB_BITS + 1;

   localparam logic signed [STATE_BITS-1:0] POLE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
   localparam logic signed [STATE_BITS-1:0] POLE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
   localparam logic signed [FB_BITS-1:0]    FB_ONE   = FB_BITS'(64'd1 << POLE_FRAC);

   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          loaded_ff, loaded_in;
   logic signed [STATE_BITS-1:0]  scaled_ff, scaled_in;
   logic signed [FB_BITS-1:0]     fb_ff, fb_in;
   logic                          scaled_vld_ff, scaled_vld_in;
   logic signed [STATE_BITS-1:0]  mix_ff, mix_in;
   logic                          mix_vld_ff, mix_vld_in;

   logic signed [PROD_BITS-1:0]      prod;
   logic signed [EXT_BITS-1:0]       prod_ext;
   logic signed [EXT_BITS-1:0]       scaled_wide;
   logic [EXT_BITS-STATE_BITS:0]     scaled_top;
   logic                             scaled_ovf;
   logic signed [FB_PROD_BITS-1:0]   fb_prod;
   logic signed [FB_BITS-1:0]        fb_floor;
   logic signed [DIFF_BITS-1:0]      diff;
   logic [DIFF_BITS-STATE_BITS:0]    diff_top;
   logic                             diff_ovf;

   // input gain, rescaled to pole format
   always_comb begin
      prod        = sample_ff * signed'({1'b0, input_gain});
      prod_ext    = EXT_BITS'(prod);
      scaled_wide = (prod_ext <<< SHL) >>> SHR;
      scaled_top  = scaled_wide[EXT_BITS-1:STATE_BITS-1];
      scaled_ovf  = !((&scaled_top) || !(|scaled_top));
      if (scaled_ovf) begin
         scaled_in = scaled_wide[EXT_BITS-1] ? POLE_MIN : POLE_MAX;
      end else begin
         scaled_in = scaled_wide[STATE_BITS-1:0];
      end
   end

   // resonance feedback, floor shift, clamped above at one
   always_comb begin
      fb_prod  = stage_four * signed'({1'b0, resonance_amount});
      fb_floor = fb_prod[FB_PROD_BITS-1:RES_FRAC];
      fb_in    = (fb_floor > FB_ONE) ? FB_ONE : fb_floor;
   end

   always_comb begin
      diff     = DIFF_BITS'(scaled_ff) - DIFF_BITS'(fb_ff);
      diff_top = diff[DIFF_BITS-1:STATE_BITS-1];
      diff_ovf = !((&diff_top) || !(|diff_top));
      if (diff_ovf) begin
         mix_in = diff[DIFF_BITS-1] ? POLE_MIN : POLE_MAX;
      end else begin
         mix_in = diff[STATE_BITS-1:0];
      end
   end

   always_comb begin
      sample_in     = start ? sample : sample_ff;
      loaded_in     = start;
      scaled_vld_in = loaded_ff;
      mix_vld_in    = scaled_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= 1'b0;
         scaled_vld_ff <= 1'b0;
         mix_vld_ff    <= 1'b0;
      end else begin
         loaded_ff     <= loaded_in;
         scaled_vld_ff <= scaled_vld_in;
         mix_vld_ff    <= mix_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      scaled_ff <= scaled_in;
      fb_ff     <= fb_in;
      mix_ff    <= mix_in;
   end

   assign mix         = mix_ff;
   assign mix_valid   = mix_vld_ff;
   assign busy.loaded = loaded_ff;
   assign busy.scaled = scaled_vld_ff;
   assign busy.mixed  = mix_vld_ff;

endmodule

### rtl/core/lad_pole_cell.sv
`timescale 1ns / 1ps

module lad_pole_cell #(
   parameter int STATE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tok_in,
   input  logic signed [STATE_BITS-1:0] prev,
   input  lad_pkg::coef_type            cutoff,
   output logic signed [STATE_BITS-1:0] pole,
   output logic                         tok_out
);
   import lad_pkg::*;

   localparam int DIFF_BITS = STATE_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + COEF_BITS + 1;
   localparam int STEP_BITS = PROD_BITS - CUT_FRAC;
   localparam int SUM_BITS  = STATE_BITS + 2;

   localparam logic signed [STATE_BITS-1:0] POLE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
   localparam logic signed [STATE_BITS-1:0] POLE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

   logic signed [STATE_BITS-1:0] pole_ff, pole_in;
   logic                         tok_ff, tok_in_d;

   logic signed [DIFF_BITS-1:0]  diff;
   logic signed [PROD_BITS-1:0]  prod;
   logic signed [STEP_BITS-1:0]  step;
   logic signed [SUM_BITS-1:0]   sum;
   logic [2:0]                   sum_top;
   logic signed [STATE_BITS-1:0] pole_sat;

   // pole += floor((prev - pole) * cutoff / 2^16)
   always_comb begin
      diff    = DIFF_BITS'(prev) - DIFF_BITS'(pole_ff);
      prod    = diff * signed'({1'b0, cutoff});
      step    = prod[PROD_BITS-1:CUT_FRAC];
      sum     = SUM_BITS'(pole_ff) + SUM_BITS'(step);
      sum_top = sum[SUM_BITS-1:STATE_BITS-1];
      if ((&sum_top) || !(|sum_top)) begin
         pole_sat = sum[STATE_BITS-1:0];
      end else begin
         pole_sat = sum[SUM_BITS-1] ? POLE_MIN : POLE_MAX;
      end
      pole_in  = tok_in ? pole_sat : pole_ff;
      tok_in_d = tok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_ff <= '0;
         tok_ff  <= 1'b0;
      end else begin
         pole_ff <= pole_in;
         tok_ff  <= tok_in_d;
      end
   end

   assign pole    = pole_ff;
   assign tok_out = tok_ff;

endmodule

### rtl/core/lad_out.sv
`timescale 1ns / 1ps

module lad_out #(
   parameter int SAMPLE_BITS = 16,
   parameter int STATE_BITS  = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         done,
   input  logic signed [STATE_BITS-1:0] stage_four,
   input  lad_pkg::coef_type            output_gain,
   input  logic                         out_ready,
   output logic                         out_valid,
   output logic [SAMPLE_BITS-1:0]       out_data,
   output logic                         pending
);
   import lad_pkg::*;

   localparam int POLE_FRAC = STATE_BITS - POLE_INT;
   localparam int SHIFT     = POLE_FRAC + GAIN_FRAC - (SAMPLE_BITS - 1);
   localparam int SHR       = (SHIFT > 0) ? SHIFT : 0;
   localparam int SHL       = (SHIFT < 0) ? -SHIFT : 0;
   localparam int PROD_BITS = STATE_BITS + COEF_BITS + 1;
   localparam int EXT_BITS  = PROD_BITS + SHL + 1;

   localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                   pend_ff, pend_in;
   logic                   vld_ff, vld_in;
   logic [SAMPLE_BITS-1:0] data_ff, data_in;

   logic signed [PROD_BITS-1:0]   prod;
   logic signed [EXT_BITS-1:0]    prod_ext;
   logic signed [EXT_BITS-1:0]    y_wide;
   logic [EXT_BITS-SAMPLE_BITS:0] y_top;
   logic [SAMPLE_BITS-1:0]        y_sat;
   logic                          want;
   logic                          load;

   always_comb begin
      prod     = stage_four * signed'({1'b0, output_gain});
      prod_ext = EXT_BITS'(prod);
      y_wide   = (prod_ext <<< SHL) >>> SHR;
      y_top    = y_wide[EXT_BITS-1:SAMPLE_BITS-1];
      if ((&y_top) || !(|y_top)) begin
         y_sat = y_wide[SAMPLE_BITS-1:0];
      end else begin
         y_sat = y_wide[EXT_BITS-1] ? OUT_MIN : OUT_MAX;
      end
   end

   // stage_four holds while a result is pending, so it is read at load time
   always_comb begin
      want    = pend_ff | done;
      load    = want & (!vld_ff | out_ready);
      pend_in = want & !load;
      vld_in  = load | (vld_ff & !out_ready);
      data_in = load ? y_sat : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;
   assign pending   = pend_ff;

endmodule

### rtl/core/four_pole_ladder_lowpass.sv
`timescale 1ns / 1ps
// four-pole ladder lowpass with resonance feedback, fixed point
//
// req_* : stream of signed samples, one per transfer
// rsp_* : stream of filtered samples, exactly one per accepted sample, in order
// csr_* : register port for cutoff, resonance and the two gains; write only
//         while no sample is in flight
//
// a sample walks through input scaling (gain and feedback products), the
// feedback subtract, then a row of four pole cells, each updating its pole
// and handing it to the next cell for the following cycle, then the output
// gain register, which drives rsp_tvalid
// only one sample is in flight at a time: the feedback of the next sample
// needs the fourth pole of this one, so req_tready stays low while a sample
// is in the row and until its result sits in the output register
// a finished result waits in the output register while rsp_tready is low;
// the next sample is taken meanwhile and parks its result until it drains
// reset clears the registers, all poles and the output valid

module four_pole_ladder_lowpass #(
   parameter int SAMPLE_BITS = 16,
   parameter int STATE_BITS  = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: sample_in
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   // rsp_tdata: sample_out
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [lad_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [lad_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [lad_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import lad_pkg::*;

   localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   // configuration registers
   coef_type cutoff_ff, cutoff_in;
   coef_type resonance_ff, resonance_in;
   coef_type in_gain_ff, in_gain_in;
   coef_type out_gain_ff, out_gain_in;

   reg_index_type csr_index;
   logic          csr_write;
   coef_type      csr_rdata;

   logic                          req_xfer;
   logic signed [SAMPLE_BITS-1:0] sample;
   front_busy_type                front_busy;
   logic                          pending;
   logic [SAMPLE_BITS-1:0]        rsp_data;

   // pole row: index 0 is the mixed input, index NUM_POLES the fourth pole
   logic signed [STATE_BITS-1:0] pole_chain [0:NUM_POLES];
   logic [NUM_POLES:0]           tok;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cutoff_in    = cutoff_ff;
      resonance_in = resonance_ff;
      in_gain_in   = in_gain_ff;
      out_gain_in  = out_gain_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CUTOFF:    cutoff_in    = csr_pwdata[COEF_BITS-1:0];
            REG_RESONANCE: resonance_in = csr_pwdata[COEF_BITS-1:0];
            REG_IN_GAIN:   in_gain_in   = csr_pwdata[COEF_BITS-1:0];
            REG_OUT_GAIN:  out_gain_in  = csr_pwdata[COEF_BITS-1:0];
            default:       cutoff_in    = cutoff_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CUTOFF:    csr_rdata = cutoff_ff;
         REG_RESONANCE: csr_rdata = resonance_ff;
         REG_IN_GAIN:   csr_rdata = in_gain_ff;
         REG_OUT_GAIN:  csr_rdata = out_gain_ff;
         default:       csr_rdata = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_BITS'(csr_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= '0;
         resonance_ff <= '0;
         in_gain_ff   <= '0;
         out_gain_ff  <= '0;
      end else begin
         cutoff_ff    <= cutoff_in;
         resonance_ff <= resonance_in;
         in_gain_ff   <= in_gain_in;
         out_gain_ff  <= out_gain_in;
      end
   end

   // ---------------- input side ----------------
   // one sample in flight at a time: ready only when the row is empty
   assign req_tready = !(front_busy.loaded | front_busy.scaled | front_busy.mixed |
                         (|tok[NUM_POLES:1]) | pending);
   assign req_xfer   = req_tvalid & req_tready;
   assign sample     = signed'(req_tdata[SAMPLE_BITS-1:0]);

   lad_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .STATE_BITS  (STATE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (req_xfer),
      .sample           (sample),
      .input_gain       (in_gain_ff),
      .resonance_amount (resonance_ff),
      .stage_four       (pole_chain[NUM_POLES]),
      .mix              (pole_chain[0]),
      .mix_valid        (tok[0]),
      .busy             (front_busy)
   );

   // ---------------- pole row ----------------
   // each cell updates once per sample when the token reaches it
   for (genvar i = 0; i < NUM_POLES; i++) begin : g_pole
      lad_pole_cell #(
         .STATE_BITS (STATE_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[i]),
         .prev    (pole_chain[i]),
         .cutoff  (cutoff_ff),
         .pole    (pole_chain[i+1]),
         .tok_out (tok[i+1])
      );
   end

   // ---------------- output side ----------------
   lad_out #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .STATE_BITS  (STATE_BITS)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .done        (tok[NUM_POLES]),
      .stage_four  (pole_chain[NUM_POLES]),
      .output_gain (out_gain_ff),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_data    (rsp_data),
      .pending     (pending)
   );

   assign rsp_tdata = DATA_BITS'(rsp_data);

`ifndef SYNTHESIS
   // never more than one sample moving through the scaling stages and the row
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0({front_busy.loaded, front_busy.scaled, tok}))
      else $error("more than one sample in flight");

   // an accepted sample blocks the input until it is finished
   a_block_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input taken while a sample is in flight");

   // the last cell update always leaves a result presented
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      tok[NUM_POLES] |=> rsp_tvalid)
      else $error("fourth pole updated without a result");
`endif

endmodule
